### rtl/nested_comment_stripper_macros.svh
// Assertion helpers shared by the stripper modules.
// Both expect signals named clk and rst in the scope of use.
`ifndef NESTED_COMMENT_STRIPPER_MACROS_SVH
`define NESTED_COMMENT_STRIPPER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define NCS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ncs assertion failed");

// Next-cycle implication, disabled during reset.
`define NCS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ncs assertion failed");

`endif

### rtl/ncs_pkg.sv
// ----------------------------------------------------------------------------
// ncs_pkg
// Types and constants shared by the nested comment stripper modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ncs_pkg;

  localparam int NEST_BITS  = 8;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int ADDR_W     = 3;

  localparam logic [NEST_BITS-1:0] NEST_MAX = {NEST_BITS{1'b1}};

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Word index of the configuration register.
  localparam logic [ADDR_W-3:0] REG_SPACES = '0;

  // Number of bytes a record carries.
  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;

  typedef enum logic [2:0] {
    MODE_PLAIN = 3'b001,
    MODE_LINE  = 3'b010,
    MODE_BLOCK = 3'b100
  } mode_t;

  typedef struct packed {
    logic [7:0] text_char;
    logic       is_last;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       run_last;
    logic       text_end;
  } out_beat_t;

  // What the scanner hands to the back end for one input byte.
  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] ch0;
    logic [7:0] ch1;
    logic       last;
  } rec_t;

endpackage

`default_nettype wire

### rtl/nested_comment_stripper.sv
// ----------------------------------------------------------------------------
// nested_comment_stripper
// Removes line and nested block comments from a byte stream.
// ----------------------------------------------------------------------------
// Each byte's record is registered in the queue between scanner and
// emitter and shown from its head. Throughput: one input byte per cycle
// while it is not full; a byte with two result bytes gives a beat per byte,
// the four-record queue absorbs such bursts. full follows queue fill alone.
// Reset (synchronous, rst high): scan state to plain text, queue empty,
// the comment blanking option cleared. No clearing pass is needed.
`default_nettype none

module nested_comment_stripper (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // Input queue side.
  input  wire logic                      push,
  output logic                           full,
  input  wire ncs_pkg::in_beat_t         text,
  // Result queue side.
  output logic                           empty,
  input  wire logic                      pop,
  output ncs_pkg::out_beat_t             result,
  // Configuration port.
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [ncs_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]               pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import ncs_pkg::*;

  // When set, removed comment bytes other than newlines become spaces.
  logic blank_comments;

  logic accept;
  rec_t scan_rec;
  logic scan_rec_valid;
  rec_t head;
  logic head_pop;
  logic q_full;
  logic q_empty;

  // The register file is a single word; the port never waits.
  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_W-1:2] == REG_SPACES) ? {31'd0, blank_comments} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      blank_comments <= 1'b0;
    end else if (psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_SPACES)) begin
      blank_comments <= pwdata[0];
    end
  end

  // A beat is taken whenever the record queue has a free slot, so the
  // scanner runs at full rate while results wait at the far side.
  assign full   = q_full;
  assign accept = push && !q_full;

  ncs_scanner u_scanner (
    .clk       (clk),
    .rst       (rst),
    .spaces    (blank_comments),
    .accept    (accept),
    .text      (text),
    .rec       (scan_rec),
    .rec_valid (scan_rec_valid)
  );

  // Bytes that produce nothing (and are not the last) leave no record.
  ncs_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr     (scan_rec_valid),
    .wr_rec (scan_rec),
    .rd     (head_pop),
    .head   (head),
    .full   (q_full),
    .empty  (q_empty)
  );

  assign empty = q_empty;

  ncs_emitter u_emitter (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_empty (q_empty),
    .pop        (pop),
    .result     (result),
    .head_pop   (head_pop)
  );

endmodule

`default_nettype wire

### rtl/ncs_scanner.sv
// ----------------------------------------------------------------------------
// ncs_scanner
// Front end: classifies each input byte and turns it into a record of up to
// two output bytes, updating the comment scan state.
// ----------------------------------------------------------------------------
`default_nettype none

`include "nested_comment_stripper_macros.svh"

module ncs_scanner (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            spaces,
  input  wire logic            accept,
  input  wire ncs_pkg::in_beat_t text,
  output ncs_pkg::rec_t        rec,
  output logic                 rec_valid
);
  import ncs_pkg::*;

  mode_t                mode, mode_next;
  logic [NEST_BITS-1:0] depth, depth_next;
  logic                 slash_held, slash_held_next;
  logic                 prev_star, prev_star_next;
  logic                 nl_run, nl_run_next;

  always_comb begin
    logic                 nl;
    logic                 is_slash;
    logic                 is_star;
    logic [NEST_BITS-1:0] depth_dec;
    logic [1:0]           removed_cnt;
    nl          = (text.text_char == CH_CR) || (text.text_char == CH_LF);
    is_slash    = (text.text_char == CH_SLASH);
    is_star     = (text.text_char == CH_STAR);
    depth_dec   = (depth != '0) ? depth - 1'b1 : depth;
    removed_cnt = spaces ? CNT_ONE : CNT_NONE;

    mode_next       = mode;
    depth_next      = depth;
    slash_held_next = slash_held;
    prev_star_next  = prev_star;
    nl_run_next     = nl_run;
    rec.cnt         = CNT_NONE;
    rec.ch0         = 8'h00;
    rec.ch1         = 8'h00;
    rec.last        = text.is_last;

    priority if (mode == MODE_LINE) begin
      if (nl) begin
        rec.cnt   = CNT_ONE;
        rec.ch0   = text.text_char;
        mode_next = MODE_PLAIN;
      end else begin
        rec.cnt = removed_cnt;
        rec.ch0 = spaces ? CH_SPACE : 8'h00;
      end
    end else if (mode == MODE_BLOCK) begin
      if (nl) begin
        if (!nl_run) begin
          rec.cnt = CNT_TWO;
          rec.ch0 = CH_CR;
          rec.ch1 = CH_LF;
        end
        nl_run_next     = 1'b1;
        slash_held_next = 1'b0;
        prev_star_next  = 1'b0;
      end else begin
        nl_run_next = 1'b0;
        rec.cnt     = removed_cnt;
        rec.ch0     = spaces ? CH_SPACE : 8'h00;
        priority if (is_slash && prev_star) begin
          slash_held_next = 1'b0;
          prev_star_next  = 1'b0;
          depth_next      = depth_dec;
          if (depth_dec == '0) begin
            mode_next = MODE_PLAIN;
          end
        end else if (is_slash) begin
          slash_held_next = 1'b1;
          prev_star_next  = 1'b0;
        end else if (is_star) begin
          if (slash_held && (depth != NEST_MAX)) begin
            depth_next = depth + 1'b1;
          end
          slash_held_next = 1'b0;
          prev_star_next  = 1'b1;
        end else begin
          slash_held_next = 1'b0;
          prev_star_next  = 1'b0;
        end
      end
    end else begin
      mode_next = MODE_PLAIN;
      if (slash_held) begin
        slash_held_next = 1'b0;
        priority if (is_slash) begin
          rec.cnt   = spaces ? CNT_TWO : CNT_NONE;
          rec.ch0   = spaces ? CH_SPACE : 8'h00;
          rec.ch1   = spaces ? CH_SPACE : 8'h00;
          mode_next = MODE_LINE;
        end else if (is_star) begin
          rec.cnt        = spaces ? CNT_TWO : CNT_NONE;
          rec.ch0        = spaces ? CH_SPACE : 8'h00;
          rec.ch1        = spaces ? CH_SPACE : 8'h00;
          mode_next      = MODE_BLOCK;
          depth_next     = NEST_BITS'(1);
          prev_star_next = 1'b1;
          nl_run_next    = 1'b0;
        end else begin
          rec.cnt = CNT_TWO;
          rec.ch0 = CH_SLASH;
          rec.ch1 = text.text_char;
        end
      end else if (is_slash) begin
        if (text.is_last) begin
          rec.cnt = CNT_ONE;
          rec.ch0 = CH_SLASH;
        end else begin
          slash_held_next = 1'b1;
        end
      end else begin
        rec.cnt = CNT_ONE;
        rec.ch0 = text.text_char;
      end
    end

    if (text.is_last) begin
      mode_next       = MODE_PLAIN;
      depth_next      = '0;
      slash_held_next = 1'b0;
      prev_star_next  = 1'b0;
      nl_run_next     = 1'b0;
    end

    rec_valid = accept && ((rec.cnt != CNT_NONE) || text.is_last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_PLAIN;
      depth      <= '0;
      slash_held <= 1'b0;
      prev_star  <= 1'b0;
      nl_run     <= 1'b0;
    end else if (accept) begin
      mode       <= mode_next;
      depth      <= depth_next;
      slash_held <= slash_held_next;
      prev_star  <= prev_star_next;
      nl_run     <= nl_run_next;
    end
  end

  `NCS_ASSERT_NEXT(a_last_clears, accept && text.is_last,
                   (mode == MODE_PLAIN) && (depth == '0) && !slash_held && !prev_star)
  `NCS_ASSERT_IMPL(a_block_has_depth, mode == MODE_BLOCK, depth != '0)
  `NCS_ASSERT_IMPL(a_line_no_slash, mode == MODE_LINE, !slash_held && !prev_star)

endmodule

`default_nettype wire

### rtl/ncs_fifo.sv
// ----------------------------------------------------------------------------
// ncs_fifo
// Short record queue between the scanner and the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

`include "nested_comment_stripper_macros.svh"

module ncs_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr,
  input  wire ncs_pkg::rec_t wr_rec,
  input  wire logic          rd,
  output ncs_pkg::rec_t      head,
  output logic               full,
  output logic               empty
);
  import ncs_pkg::*;

  rec_t             mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign head  = mem[rd_ptr];
  assign full  = (count == (PTR_W+1)'(FIFO_DEPTH));
  assign empty = (count == '0);

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

  `NCS_ASSERT_IMPL(a_no_overflow, wr, !full)
  `NCS_ASSERT_IMPL(a_no_underflow, rd, !empty)
  `NCS_ASSERT_IMPL(a_count_range, 1'b1, count <= (PTR_W+1)'(FIFO_DEPTH))

endmodule

`default_nettype wire

### rtl/ncs_emitter.sv
// ----------------------------------------------------------------------------
// ncs_emitter
// Back end: walks the bytes of the record at the queue head, one beat each.
// ----------------------------------------------------------------------------
`default_nettype none

module ncs_emitter (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire ncs_pkg::rec_t head,
  input  wire logic          head_empty,
  input  wire logic          pop,
  output ncs_pkg::out_beat_t result,
  output logic               head_pop
);
  import ncs_pkg::*;

  // Set while the second byte of a two-byte record is on show.
  logic second;

  always_comb begin
    result.out_char   = second ? head.ch1 : head.ch0;
    result.char_valid = (head.cnt != CNT_NONE);
    result.run_last   = second || (head.cnt != CNT_TWO);
    result.text_end   = result.run_last && head.last;
    head_pop          = pop && !head_empty && result.run_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      second <= 1'b0;
    end else if (pop && !head_empty) begin
      second <= !result.run_last;
    end
  end

endmodule

`default_nettype wire
